// ===== hdl/framed_byte_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// framed_byte_fifo assertion macros
// shorthand for clocked implications, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef FRAMED_BYTE_FIFO_ASSERT_SVH
`define FRAMED_BYTE_FIFO_ASSERT_SVH

// same-cycle implication
`define FBF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framed_byte_fifo: same-cycle check failed");

// next-cycle implication
`define FBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framed_byte_fifo: next-cycle check failed");

`endif

// ===== hdl/fbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_pkg
// types and codes shared by the framed byte fifo modules
// ----------------------------------------------------------------------------
package fbf_pkg;

  typedef logic [2:0] req_code_t;
  typedef logic [2:0] status_t;
  typedef logic [8:0] len_t;
  typedef logic [4:0] ready_t;

  // request codes on the input channel
  localparam req_code_t REQ_PUSH_DELIM = 3'd0;
  localparam req_code_t REQ_PUSH_RAW   = 3'd1;
  localparam req_code_t REQ_POP        = 3'd2;
  localparam req_code_t REQ_OPEN       = 3'd3;
  localparam req_code_t REQ_REOPEN     = 3'd4;
  localparam req_code_t REQ_CLOSE      = 3'd5;

  // status codes on the result channel
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_NO_FRAME  = 3'd2;
  localparam status_t ST_EXHAUSTED = 3'd3;
  localparam status_t ST_TOO_LONG  = 3'd4;

  // register index decoded from paddr[2]
  localparam logic REG_FRAME_DELIMITER = 1'b0;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DELIM,
    OP_PUSH,
    OP_POP,
    OP_OPEN,
    OP_REOPEN,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    req_code_t   req_type;
    logic [7:0]  byte_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    len_t        frame_length;
    len_t        bytes_left;
    ready_t      frames_ready;
    status_t     status;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
  } cmd_t;

endpackage

// ===== hdl/fbf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_front
// accepts requests, classifies them against the delimiter, queues them
// ----------------------------------------------------------------------------
module fbf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  fbf_pkg::in_t   request,
  input  logic [7:0]     frame_delimiter,
  output logic           cmd_valid,
  output fbf_pkg::cmd_t  cmd,
  input  logic           take
);

  fbf_pkg::cmd_t  cmd_in;
  fbf_pkg::cmd_t  queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;

  always_comb begin
    cmd_in.data = request.byte_in;
    case (request.req_type)
      fbf_pkg::REQ_PUSH_DELIM: begin
        cmd_in.op = (request.byte_in == frame_delimiter) ? fbf_pkg::OP_DELIM
                                                         : fbf_pkg::OP_PUSH;
      end
      fbf_pkg::REQ_PUSH_RAW: cmd_in.op = fbf_pkg::OP_PUSH;
      fbf_pkg::REQ_POP:      cmd_in.op = fbf_pkg::OP_POP;
      fbf_pkg::REQ_OPEN:     cmd_in.op = fbf_pkg::OP_OPEN;
      fbf_pkg::REQ_REOPEN:   cmd_in.op = fbf_pkg::OP_REOPEN;
      fbf_pkg::REQ_CLOSE:    cmd_in.op = fbf_pkg::OP_CLOSE;
      default:               cmd_in.op = fbf_pkg::OP_NONE;
    endcase
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

endmodule

// ===== hdl/fbf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_back
// executes queued requests on the byte and length stores, builds results
// ----------------------------------------------------------------------------
module fbf_back #(
  parameter int BYTE_DEPTH  = 256,
  parameter int FRAME_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  fbf_pkg::cmd_t  cmd,
  output logic           take,
  output logic           empty,
  input  logic           pop,
  output fbf_pkg::out_t  result
);

  localparam int PTR_W  = $clog2(BYTE_DEPTH);
  localparam int CNT_W  = $clog2(BYTE_DEPTH + 1);
  localparam int LPTR_W = $clog2(FRAME_DEPTH);
  localparam int FCNT_W = $clog2(FRAME_DEPTH + 1);

  // stores
  logic [7:0]        byte_mem [BYTE_DEPTH];
  logic [CNT_W-1:0]  len_mem  [FRAME_DEPTH];
  logic [7:0]        byte_rd;
  logic [CNT_W-1:0]  len_rd;

  // pointer and count state
  logic [PTR_W-1:0]  byte_write_ptr, byte_write_ptr_next;
  logic [PTR_W-1:0]  byte_read_ptr, byte_read_ptr_next;
  logic [PTR_W-1:0]  saved_read_ptr, saved_read_ptr_next;
  logic [CNT_W-1:0]  write_frame_bytes, write_frame_bytes_next;
  logic [CNT_W-1:0]  read_frame_left, read_frame_left_next;
  logic [CNT_W-1:0]  saved_frame_left, saved_frame_left_next;
  logic [LPTR_W-1:0] length_write_ptr, length_write_ptr_next;
  logic [LPTR_W-1:0] length_read_ptr, length_read_ptr_next;
  logic [FCNT_W-1:0] frame_total, frame_total_next;
  logic [CNT_W-1:0]  held_bytes, held_bytes_next;
  logic [CNT_W-1:0]  read_offset, read_offset_next;
  logic              open_wait, open_wait_next;

  // response stage
  logic              resp_valid;
  logic              resp_byte_sel;
  logic              resp_len_sel;
  fbf_pkg::status_t  resp_status;
  fbf_pkg::len_t     resp_left;
  fbf_pkg::ready_t   resp_ready;
  logic              resp_move;

  // output register
  logic              out_valid;
  fbf_pkg::out_t     out_data;
  fbf_pkg::out_t     resp_result;

  // issue-time controls
  logic              byte_we, byte_re, len_we, len_re;
  logic              byte_sel, len_sel;
  fbf_pkg::status_t  status;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  skip;
  logic [CNT_W:0]    skip_sum;

  assign resp_move = resp_valid && (!out_valid || pop);
  assign take      = cmd_valid && !open_wait && (!resp_valid || resp_move);

  assign avail    = held_bytes - read_offset;
  assign skip     = (read_frame_left < avail) ? read_frame_left : avail;
  assign skip_sum = (CNT_W+1)'(byte_read_ptr) + (CNT_W+1)'(skip);

  always_comb begin
    byte_write_ptr_next    = byte_write_ptr;
    byte_read_ptr_next     = byte_read_ptr;
    saved_read_ptr_next    = saved_read_ptr;
    write_frame_bytes_next = write_frame_bytes;
    read_frame_left_next   = read_frame_left;
    saved_frame_left_next  = saved_frame_left;
    length_write_ptr_next  = length_write_ptr;
    length_read_ptr_next   = length_read_ptr;
    frame_total_next       = frame_total;
    held_bytes_next        = held_bytes;
    read_offset_next       = read_offset;
    open_wait_next         = 1'b0;
    byte_we  = 1'b0;
    byte_re  = 1'b0;
    len_we   = 1'b0;
    len_re   = 1'b0;
    byte_sel = 1'b0;
    len_sel  = 1'b0;
    status   = fbf_pkg::ST_OK;

    // open finishes here: the length read from the store becomes the count
    if (open_wait) begin
      read_frame_left_next  = len_rd;
      saved_frame_left_next = len_rd;
    end

    if (take) begin
      case (cmd.op)
        fbf_pkg::OP_DELIM: begin
          if (frame_total >= FCNT_W'(FRAME_DEPTH)) begin
            status = fbf_pkg::ST_FULL;
          end else begin
            len_we = 1'b1;
            length_write_ptr_next = (length_write_ptr == LPTR_W'(FRAME_DEPTH - 1))
                                    ? '0 : length_write_ptr + 1'b1;
            frame_total_next       = frame_total + 1'b1;
            write_frame_bytes_next = '0;
          end
        end
        fbf_pkg::OP_PUSH: begin
          if (write_frame_bytes >= CNT_W'(BYTE_DEPTH)) begin
            status = fbf_pkg::ST_TOO_LONG;
          end else if (held_bytes >= CNT_W'(BYTE_DEPTH)) begin
            status = fbf_pkg::ST_FULL;
          end else begin
            byte_we = 1'b1;
            byte_write_ptr_next = (byte_write_ptr == PTR_W'(BYTE_DEPTH - 1))
                                  ? '0 : byte_write_ptr + 1'b1;
            write_frame_bytes_next = write_frame_bytes + 1'b1;
            held_bytes_next        = held_bytes + 1'b1;
          end
        end
        fbf_pkg::OP_POP: begin
          if (read_frame_left == '0 || read_offset >= held_bytes) begin
            status = fbf_pkg::ST_EXHAUSTED;
          end else begin
            byte_re  = 1'b1;
            byte_sel = 1'b1;
            byte_read_ptr_next = (byte_read_ptr == PTR_W'(BYTE_DEPTH - 1))
                                 ? '0 : byte_read_ptr + 1'b1;
            read_frame_left_next = read_frame_left - 1'b1;
            read_offset_next     = read_offset + 1'b1;
          end
        end
        fbf_pkg::OP_OPEN: begin
          if (frame_total == '0) begin
            status = fbf_pkg::ST_NO_FRAME;
          end else begin
            len_re  = 1'b1;
            len_sel = 1'b1;
            open_wait_next       = 1'b1;
            held_bytes_next      = held_bytes - read_offset;
            read_offset_next     = '0;
            saved_read_ptr_next  = byte_read_ptr;
            length_read_ptr_next = (length_read_ptr == LPTR_W'(FRAME_DEPTH - 1))
                                   ? '0 : length_read_ptr + 1'b1;
            frame_total_next     = frame_total - 1'b1;
          end
        end
        fbf_pkg::OP_REOPEN: begin
          byte_read_ptr_next   = saved_read_ptr;
          read_frame_left_next = saved_frame_left;
          read_offset_next     = '0;
        end
        fbf_pkg::OP_CLOSE: begin
          // skip sum stays below twice the depth, one subtract wraps it
          byte_read_ptr_next = (skip_sum >= (CNT_W+1)'(BYTE_DEPTH))
                               ? PTR_W'(skip_sum - (CNT_W+1)'(BYTE_DEPTH))
                               : PTR_W'(skip_sum);
          read_offset_next     = read_offset + skip;
          read_frame_left_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_write_ptr    <= '0;
      byte_read_ptr     <= '0;
      saved_read_ptr    <= '0;
      write_frame_bytes <= '0;
      read_frame_left   <= '0;
      saved_frame_left  <= '0;
      length_write_ptr  <= '0;
      length_read_ptr   <= '0;
      frame_total       <= '0;
      held_bytes        <= '0;
      read_offset       <= '0;
      open_wait         <= 1'b0;
    end else begin
      byte_write_ptr    <= byte_write_ptr_next;
      byte_read_ptr     <= byte_read_ptr_next;
      saved_read_ptr    <= saved_read_ptr_next;
      write_frame_bytes <= write_frame_bytes_next;
      read_frame_left   <= read_frame_left_next;
      saved_frame_left  <= saved_frame_left_next;
      length_write_ptr  <= length_write_ptr_next;
      length_read_ptr   <= length_read_ptr_next;
      frame_total       <= frame_total_next;
      held_bytes        <= held_bytes_next;
      read_offset       <= read_offset_next;
      open_wait         <= open_wait_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_write_ptr] <= cmd.data;
    end
    if (byte_re) begin
      byte_rd <= byte_mem[byte_read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[length_write_ptr] <= write_frame_bytes;
    end
    if (len_re) begin
      len_rd <= len_mem[length_read_ptr];
    end
  end

  // response stage: read data arrives with it
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (take) begin
      resp_valid <= 1'b1;
    end else if (resp_move) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      resp_byte_sel <= byte_sel;
      resp_len_sel  <= len_sel;
      resp_status   <= status;
      resp_left     <= fbf_pkg::len_t'(read_frame_left_next);
      resp_ready    <= fbf_pkg::ready_t'(frame_total_next);
    end
  end

  always_comb begin
    resp_result.byte_out     = resp_byte_sel ? byte_rd : 8'd0;
    resp_result.frame_length = resp_len_sel ? fbf_pkg::len_t'(len_rd) : '0;
    resp_result.bytes_left   = resp_len_sel ? fbf_pkg::len_t'(len_rd) : resp_left;
    resp_result.frames_ready = resp_ready;
    resp_result.status       = resp_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_move) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_move) begin
      out_data <= resp_result;
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

endmodule

// ===== hdl/framed_byte_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_byte_fifo
// byte ring buffer with a ring of frame lengths, queue-style request channels
// ----------------------------------------------------------------------------
// Requests enter on push/full with request.req_type and request.byte_in; one
// result per request leaves on empty/pop, in request order.
// A request accepted into the front queue passes the response stage and the
// output register before its result shows, when the result side is free.
// The back end executes one request per cycle while the response stage is
// free; an open holds it until the registered length read sets the count.
// A two-entry queue sits between the classifying front and the executing
// back, and a response stage plus an output register follow, so requests
// keep flowing while a result waits; when pop stays low the back end fills
// its stages and full rises once the request queue is full.
// The delimiter register sits at byte address 0 of the APB port; it should
// be written only while no request is in flight.
// Reset empties both stores (their contents are not cleared), zeroes all
// pointers and counts and the delimiter, and drops all pending results.
// ----------------------------------------------------------------------------
`include "framed_byte_fifo_assert.svh"

module framed_byte_fifo #(
  parameter int BYTE_DEPTH  = 256,
  parameter int FRAME_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  fbf_pkg::in_t   request,
  output logic           empty,
  input  logic           pop,
  output fbf_pkg::out_t  result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic           cfg_write;
  logic [7:0]     frame_delimiter;
  logic           cmd_valid;
  fbf_pkg::cmd_t  cmd;
  logic           take;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == fbf_pkg::REG_FRAME_DELIMITER);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_delimiter <= 8'd0;
    end else if (cfg_write) begin
      frame_delimiter <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == fbf_pkg::REG_FRAME_DELIMITER)
                  ? {24'd0, frame_delimiter} : 32'd0;

  fbf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .request         (request),
    .frame_delimiter (frame_delimiter),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .take            (take)
  );

  fbf_back #(
    .BYTE_DEPTH  (BYTE_DEPTH),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // an accepted request is queued for the back end on the next cycle
  `FBF_ASSERT_NEXT(a_push_reaches_queue, push && !full, cmd_valid)

  // data or a length only come with a good status
  `FBF_ASSERT_NOW(a_payload_needs_ok, !empty && (result.byte_out != 8'd0 || result.frame_length != 9'd0), result.status == fbf_pkg::ST_OK)

  // the back end never takes a request from an empty queue
  `FBF_ASSERT_NOW(a_take_needs_request, take, cmd_valid)

  // a delimiter write lands in the register
  `FBF_ASSERT_NEXT(a_delimiter_written, cfg_write, frame_delimiter == $past(pwdata[7:0]))

endmodule
